### sv/matrix_to_euler_angles_macros.svh
// Assertion macros used by the checker file.
`ifndef MATRIX_TO_EULER_ANGLES_MACROS_SVH
`define MATRIX_TO_EULER_ANGLES_MACROS_SVH

// Clocked property, muted while reset is high.
`define M2E_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that also holds across reset.
`define M2E_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/m2e_pkg.sv
`timescale 1ns / 1ps

package m2e_pkg;

   localparam int CORDIC_STEPS = 28;
   localparam int ROOT_STEPS   = 32;
   localparam int QUOT_STEPS   = 31;
   localparam int NUM_ENTRIES  = 9;
   localparam int NUM_ROWS     = 3;
   localparam int NUM_LANES    = 5;
   localparam int NUM_ANGLES   = 3;

   // divider lanes: r11, r21, r31, r32, r33
   localparam int LANE_R11 = 0;
   localparam int LANE_R21 = 1;
   localparam int LANE_R31 = 2;
   localparam int LANE_R32 = 3;
   localparam int LANE_R33 = 4;

   localparam int LANE_ENTRY [NUM_LANES] = '{0, 3, 6, 7, 8};
   localparam int LANE_ROW   [NUM_LANES] = '{0, 1, 2, 2, 2};

   localparam int ANG_YAW   = 0;
   localparam int ANG_PITCH = 1;
   localparam int ANG_ROLL  = 2;

   localparam logic signed [31:0] PI_Q28      = 32'sd843314857;
   localparam logic signed [31:0] HALF_PI_Q28 = 32'sd421657428;

   // atan(2^-i) in Q4.28, rounded to nearest
   localparam logic signed [31:0] ATAN_TABLE [CORDIC_STEPS] = '{
      32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
      32'sd16755422,  32'sd8385879,   32'sd4193963,  32'sd2097109,
      32'sd1048571,   32'sd524287,    32'sd262144,   32'sd131072,
      32'sd65536,     32'sd32768,     32'sd16384,    32'sd8192,
      32'sd4096,      32'sd2048,      32'sd1024,     32'sd512,
      32'sd256,       32'sd128,       32'sd64,       32'sd32,
      32'sd16,        32'sd8,         32'sd4,        32'sd2
   };

   typedef struct packed {
      logic [63:0] rem;
      logic [63:0] root;
   } root_type;

   typedef struct packed {
      logic [32:0] rem;
      logic [30:0] quo;
   } quot_type;

   typedef struct packed {
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [31:0] z;
   } rot_type;

endpackage

### sv/m2e_channels.sv
`timescale 1ns / 1ps

interface m2e_req_if #(parameter int ENTRY_WIDTH = 32);
   logic                          valid;
   logic                          ready;
   logic signed [ENTRY_WIDTH-1:0] row1_col1;
   logic signed [ENTRY_WIDTH-1:0] row1_col2;
   logic signed [ENTRY_WIDTH-1:0] row1_col3;
   logic signed [ENTRY_WIDTH-1:0] row2_col1;
   logic signed [ENTRY_WIDTH-1:0] row2_col2;
   logic signed [ENTRY_WIDTH-1:0] row2_col3;
   logic signed [ENTRY_WIDTH-1:0] row3_col1;
   logic signed [ENTRY_WIDTH-1:0] row3_col2;
   logic signed [ENTRY_WIDTH-1:0] row3_col3;

   modport source (output valid, row1_col1, row1_col2, row1_col3, row2_col1, row2_col2,
                   row2_col3, row3_col1, row3_col2, row3_col3, input ready);
   modport sink   (input valid, row1_col1, row1_col2, row1_col3, row2_col1, row2_col2,
                   row2_col3, row3_col1, row3_col2, row3_col3, output ready);
endinterface

interface m2e_rsp_if #(parameter int ANGLE_WIDTH = 32);
   logic                          valid;
   logic                          ready;
   logic signed [ANGLE_WIDTH-2:0] yaw_angle;
   logic signed [ANGLE_WIDTH-2:0] pitch_angle;
   logic signed [ANGLE_WIDTH-2:0] roll_angle;
   logic                          degenerate;

   modport source (output valid, yaw_angle, pitch_angle, roll_angle, degenerate,
                   input ready);
   modport sink   (input valid, yaw_angle, pitch_angle, roll_angle, degenerate,
                   output ready);
endinterface

### sv/matrix_to_euler_angles.sv
`timescale 1ns / 1ps

// ZYX Euler-angle extractor. Each beat on req_bus carries the nine rotation/scale
// entries of an affine transform (signed Q16.16 at ENTRY_WIDTH 32); each beat on
// rsp_bus returns yaw = atan2(r21, r11), pitch = atan2(-r31, hypot(r32, r33)) and
// roll = atan2(r32, r33) in signed Q3.(ANGLE_WIDTH-4) radians, where each rij is
// the entry divided by its row's Euclidean length. A zero row sets degenerate and
// zeroes all angles. Throughput is one matrix per clock while the skid is empty.
// The datapath is two 32-stage square-root pipelines (row lengths, then hypot),
// a 31-stage restoring divider and a 28-stage CORDIC, plus seven single stages
// around them. A skid register behind the last stage lets the pipeline still move
// in the cycle rsp_bus stalls; req_bus.ready drops only while the skid is full.
module matrix_to_euler_angles #(
   parameter int ENTRY_WIDTH = 32,
   parameter int ANGLE_WIDTH = 32
) (
   input logic        clock,
   input logic        reset,
   m2e_req_if.sink    req_bus,
   m2e_rsp_if.source  rsp_bus
);

   localparam int RS = m2e_pkg::ROOT_STEPS;
   localparam int QS = m2e_pkg::QUOT_STEPS;
   localparam int CS = m2e_pkg::CORDIC_STEPS;
   localparam int NL = m2e_pkg::NUM_LANES;
   localparam int NR = m2e_pkg::NUM_ROWS;
   localparam int NA = m2e_pkg::NUM_ANGLES;
   localparam int NE = m2e_pkg::NUM_ENTRIES;

   localparam int ESHIFT = (ENTRY_WIDTH > 32) ? ENTRY_WIDTH - 32 : 0;
   localparam int A_UP   = (ANGLE_WIDTH - 4 >= 28) ? ANGLE_WIDTH - 32 : 0;
   localparam int A_DOWN = (ANGLE_WIDTH - 4 < 28) ? 32 - ANGLE_WIDTH : 0;

   // ---------------------------------------------------------------- helpers
   function automatic logic signed [31:0] load_entry(input logic [ENTRY_WIDTH-1:0] raw);
      logic signed [ENTRY_WIDTH-1:0] sh;
      logic signed [63:0]            wide;
      sh   = $signed(raw) >>> ESHIFT;   // floor shift for wide entries
      wide = 64'(sh);
      return wide[31:0];
   endfunction

   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      logic signed [32:0] w;
      w = 33'(v);
      if (v[31]) w = -w;
      return w[31:0];
   endfunction

   // one step of the bit-pair square root
   function automatic m2e_pkg::root_type root_step(input m2e_pkg::root_type a,
                                                   input int k);
      m2e_pkg::root_type f;
      logic [63:0]       bit_v;
      logic [63:0]       trial;
      bit_v = 64'd1 << (62 - 2 * k);
      trial = a.root + bit_v;
      if (a.rem >= trial) begin
         f.rem  = a.rem - trial;
         f.root = (a.root >> 1) + bit_v;
      end else begin
         f.rem  = a.rem;
         f.root = a.root >> 1;
      end
      return f;
   endfunction

   // one quotient bit of the restoring divider
   function automatic m2e_pkg::quot_type quot_step(input m2e_pkg::quot_type a,
                                                   input logic [31:0] s);
      m2e_pkg::quot_type f;
      logic [32:0]       r;
      logic              b;
      r = a.rem;
      b = (r >= {1'b0, s});
      if (b) r = r - {1'b0, s};
      f.rem = {r[31:0], 1'b0};
      f.quo = {a.quo[29:0], b};
      return f;
   endfunction

   // quadrant fold so CORDIC starts in the right half plane
   function automatic m2e_pkg::rot_type rot_init(input logic signed [33:0] y,
                                                 input logic signed [33:0] x);
      m2e_pkg::rot_type f;
      if (x[33]) begin
         if (!y[33]) begin
            f.x = y;
            f.y = -x;
            f.z = m2e_pkg::HALF_PI_Q28;
         end else begin
            f.x = -y;
            f.y = x;
            f.z = -m2e_pkg::HALF_PI_Q28;
         end
      end else begin
         f.x = x;
         f.y = y;
         f.z = 32'sd0;
      end
      return f;
   endfunction

   function automatic m2e_pkg::rot_type rot_step(input m2e_pkg::rot_type a, input int i);
      m2e_pkg::rot_type   f;
      logic signed [33:0] dx;
      logic signed [33:0] dy;
      dx = a.y >>> i;
      dy = a.x >>> i;
      if (!a.y[33]) begin
         f.x = a.x + dx;
         f.y = a.y - dy;
         f.z = a.z + m2e_pkg::ATAN_TABLE[i];
      end else begin
         f.x = a.x - dx;
         f.y = a.y + dy;
         f.z = a.z - m2e_pkg::ATAN_TABLE[i];
      end
      return f;
   endfunction

   function automatic logic [ANGLE_WIDTH-2:0] emit_angle(input logic signed [31:0] z);
      logic signed [31:0] c;
      logic signed [63:0] w;
      c = z;
      if (c > m2e_pkg::PI_Q28) c = m2e_pkg::PI_Q28;
      else if (c < -m2e_pkg::PI_Q28) c = -m2e_pkg::PI_Q28;
      w = 64'(c);
      w = (w >>> A_DOWN) <<< A_UP;
      return w[ANGLE_WIDTH-2:0];
   endfunction

   // ---------------------------------------------------------------- handshake
   logic adv;           // whole pipeline moves
   logic sk_full_ff;
   logic sk_full_in;

   assign adv           = !sk_full_ff;
   assign req_bus.ready = adv;

   logic [ENTRY_WIDTH-1:0] raw [NE];
   assign raw[0] = req_bus.row1_col1;
   assign raw[1] = req_bus.row1_col2;
   assign raw[2] = req_bus.row1_col3;
   assign raw[3] = req_bus.row2_col1;
   assign raw[4] = req_bus.row2_col2;
   assign raw[5] = req_bus.row2_col3;
   assign raw[6] = req_bus.row3_col1;
   assign raw[7] = req_bus.row3_col2;
   assign raw[8] = req_bus.row3_col3;

   // ---------------------------------------------------------------- pipeline regs
   // front: load, square, row sums
   logic               a_vld_ff, b_vld_ff, c_vld_ff;
   logic signed [31:0] a_e_ff   [NE];
   logic [63:0]        b_sq_ff  [NE];
   logic signed [31:0] b_e_ff   [NL];
   logic               b_degen_ff;
   logic [63:0]        c_sum_ff [NR];
   logic signed [31:0] c_e_ff   [NL];
   logic               c_degen_ff;

   // row lengths
   logic [RS-1:0]      q_vld_ff;
   m2e_pkg::root_type  q_ff      [RS][NR];
   logic signed [31:0] q_e_ff    [RS][NL];
   logic               q_degen_ff[RS];

   // normalization
   logic [QS-1:0]      d_vld_ff;
   m2e_pkg::quot_type  d_ff      [QS][NL];
   logic               d_neg_ff  [QS][NL];
   logic [31:0]        d_s_ff    [QS][NR];
   logic               d_degen_ff[QS];

   // hypot(r32, r33)
   logic               h1_vld_ff, h2_vld_ff;
   logic signed [31:0] h1_r_ff   [NL];
   logic [61:0]        h1_sq_ff  [2];
   logic               h1_degen_ff;
   logic [63:0]        h2_sum_ff;
   logic signed [31:0] h2_r_ff   [NL];
   logic               h2_degen_ff;
   logic [RS-1:0]      hq_vld_ff;
   m2e_pkg::root_type  hq_ff      [RS];
   logic signed [31:0] hq_r_ff    [RS][NL];
   logic               hq_degen_ff[RS];

   // CORDIC: slot 0 is the quadrant fold, then one micro-rotation per stage
   logic [CS:0]        k_vld_ff;
   m2e_pkg::rot_type   k_ff      [CS+1][NA];
   logic               k_zero_ff [CS+1][NA];
   logic               k_degen_ff[CS+1];

   // output stage and skid
   logic                   o_vld_ff;
   logic [ANGLE_WIDTH-2:0] o_ang_ff  [NA];
   logic                   o_degen_ff;
   logic [ANGLE_WIDTH-2:0] sk_ang_ff [NA];
   logic                   sk_degen_ff;

   logic [31:0]        hyp;
   logic signed [33:0] ky [NA];
   logic signed [33:0] kx [NA];

   assign hyp = hq_ff[RS-1].root[31:0];
   assign ky[m2e_pkg::ANG_YAW]   = 34'(hq_r_ff[RS-1][m2e_pkg::LANE_R21]);
   assign kx[m2e_pkg::ANG_YAW]   = 34'(hq_r_ff[RS-1][m2e_pkg::LANE_R11]);
   assign ky[m2e_pkg::ANG_PITCH] = -34'(hq_r_ff[RS-1][m2e_pkg::LANE_R31]);
   assign kx[m2e_pkg::ANG_PITCH] = $signed({2'b00, hyp});
   assign ky[m2e_pkg::ANG_ROLL]  = 34'(hq_r_ff[RS-1][m2e_pkg::LANE_R32]);
   assign kx[m2e_pkg::ANG_ROLL]  = 34'(hq_r_ff[RS-1][m2e_pkg::LANE_R33]);

   // ---------------------------------------------------------------- datapath
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < NE; k++) begin
            a_e_ff[k]  <= load_entry(raw[k]);
            b_sq_ff[k] <= 64'(mag32(a_e_ff[k])) * 64'(mag32(a_e_ff[k]));
         end
         for (int l = 0; l < NL; l++) b_e_ff[l] <= a_e_ff[m2e_pkg::LANE_ENTRY[l]];
         b_degen_ff <= (a_e_ff[0] == 32'sd0 && a_e_ff[1] == 32'sd0 && a_e_ff[2] == 32'sd0)
                    || (a_e_ff[3] == 32'sd0 && a_e_ff[4] == 32'sd0 && a_e_ff[5] == 32'sd0)
                    || (a_e_ff[6] == 32'sd0 && a_e_ff[7] == 32'sd0 && a_e_ff[8] == 32'sd0);

         for (int r = 0; r < NR; r++)
            c_sum_ff[r] <= b_sq_ff[3*r] + b_sq_ff[3*r+1] + b_sq_ff[3*r+2];
         c_e_ff     <= b_e_ff;
         c_degen_ff <= b_degen_ff;

         // row length square roots
         for (int r = 0; r < NR; r++)
            q_ff[0][r] <= root_step(m2e_pkg::root_type'({c_sum_ff[r], 64'd0}), 0);
         q_e_ff[0]     <= c_e_ff;
         q_degen_ff[0] <= c_degen_ff;
         for (int k = 1; k < RS; k++) begin
            for (int r = 0; r < NR; r++) q_ff[k][r] <= root_step(q_ff[k-1][r], k);
            q_e_ff[k]     <= q_e_ff[k-1];
            q_degen_ff[k] <= q_degen_ff[k-1];
         end

         // |e| * 2^30 / s, one quotient bit per stage
         for (int l = 0; l < NL; l++) begin
            d_ff[0][l] <= quot_step(
               m2e_pkg::quot_type'({1'b0, mag32(q_e_ff[RS-1][l]), 31'd0}),
               q_ff[RS-1][m2e_pkg::LANE_ROW[l]].root[31:0]);
            d_neg_ff[0][l] <= q_e_ff[RS-1][l][31];
         end
         for (int r = 0; r < NR; r++) d_s_ff[0][r] <= q_ff[RS-1][r].root[31:0];
         d_degen_ff[0] <= q_degen_ff[RS-1];
         for (int k = 1; k < QS; k++) begin
            for (int l = 0; l < NL; l++)
               d_ff[k][l] <= quot_step(d_ff[k-1][l], d_s_ff[k-1][m2e_pkg::LANE_ROW[l]]);
            d_neg_ff[k]   <= d_neg_ff[k-1];
            d_s_ff[k]     <= d_s_ff[k-1];
            d_degen_ff[k] <= d_degen_ff[k-1];
         end

         // signed ratios and hypot squares (|r| is the raw quotient)
         for (int l = 0; l < NL; l++)
            h1_r_ff[l] <= d_neg_ff[QS-1][l] ? -$signed({1'b0, d_ff[QS-1][l].quo})
                                            :  $signed({1'b0, d_ff[QS-1][l].quo});
         h1_sq_ff[0] <= 62'(d_ff[QS-1][m2e_pkg::LANE_R32].quo)
                      * 62'(d_ff[QS-1][m2e_pkg::LANE_R32].quo);
         h1_sq_ff[1] <= 62'(d_ff[QS-1][m2e_pkg::LANE_R33].quo)
                      * 62'(d_ff[QS-1][m2e_pkg::LANE_R33].quo);
         h1_degen_ff <= d_degen_ff[QS-1];

         h2_sum_ff   <= 64'(h1_sq_ff[0]) + 64'(h1_sq_ff[1]);
         h2_r_ff     <= h1_r_ff;
         h2_degen_ff <= h1_degen_ff;

         hq_ff[0]       <= root_step(m2e_pkg::root_type'({h2_sum_ff, 64'd0}), 0);
         hq_r_ff[0]     <= h2_r_ff;
         hq_degen_ff[0] <= h2_degen_ff;
         for (int k = 1; k < RS; k++) begin
            hq_ff[k]       <= root_step(hq_ff[k-1], k);
            hq_r_ff[k]     <= hq_r_ff[k-1];
            hq_degen_ff[k] <= hq_degen_ff[k-1];
         end

         // three CORDIC lanes in lockstep
         for (int a = 0; a < NA; a++) begin
            k_ff[0][a]      <= rot_init(ky[a], kx[a]);
            k_zero_ff[0][a] <= (ky[a] == 34'sd0) && (kx[a] == 34'sd0);
         end
         k_degen_ff[0] <= hq_degen_ff[RS-1];
         for (int i = 0; i < CS; i++) begin
            for (int a = 0; a < NA; a++) k_ff[i+1][a] <= rot_step(k_ff[i][a], i);
            k_zero_ff[i+1]  <= k_zero_ff[i];
            k_degen_ff[i+1] <= k_degen_ff[i];
         end

         for (int a = 0; a < NA; a++)
            o_ang_ff[a] <= (k_degen_ff[CS] || k_zero_ff[CS][a]) ? '0
                                                                : emit_angle(k_ff[CS][a].z);
         o_degen_ff <= k_degen_ff[CS];
      end

      if (!sk_full_ff) begin
         sk_ang_ff   <= o_ang_ff;
         sk_degen_ff <= o_degen_ff;
      end
   end

   // ---------------------------------------------------------------- valids
   assign sk_full_in = sk_full_ff ? !rsp_bus.ready : (o_vld_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff   <= 1'b0;
         b_vld_ff   <= 1'b0;
         c_vld_ff   <= 1'b0;
         q_vld_ff   <= '0;
         d_vld_ff   <= '0;
         h1_vld_ff  <= 1'b0;
         h2_vld_ff  <= 1'b0;
         hq_vld_ff  <= '0;
         k_vld_ff   <= '0;
         o_vld_ff   <= 1'b0;
         sk_full_ff <= 1'b0;
      end else begin
         sk_full_ff <= sk_full_in;
         if (adv) begin
            a_vld_ff  <= req_bus.valid;
            b_vld_ff  <= a_vld_ff;
            c_vld_ff  <= b_vld_ff;
            q_vld_ff  <= {q_vld_ff[RS-2:0], c_vld_ff};
            d_vld_ff  <= {d_vld_ff[QS-2:0], q_vld_ff[RS-1]};
            h1_vld_ff <= d_vld_ff[QS-1];
            h2_vld_ff <= h1_vld_ff;
            hq_vld_ff <= {hq_vld_ff[RS-2:0], h2_vld_ff};
            k_vld_ff  <= {k_vld_ff[CS-1:0], hq_vld_ff[RS-1]};
            o_vld_ff  <= k_vld_ff[CS];
         end
      end
   end

   // ---------------------------------------------------------------- result beat
   assign rsp_bus.valid       = sk_full_ff || o_vld_ff;
   assign rsp_bus.yaw_angle   = $signed(sk_full_ff ? sk_ang_ff[m2e_pkg::ANG_YAW]
                                                   : o_ang_ff[m2e_pkg::ANG_YAW]);
   assign rsp_bus.pitch_angle = $signed(sk_full_ff ? sk_ang_ff[m2e_pkg::ANG_PITCH]
                                                   : o_ang_ff[m2e_pkg::ANG_PITCH]);
   assign rsp_bus.roll_angle  = $signed(sk_full_ff ? sk_ang_ff[m2e_pkg::ANG_ROLL]
                                                   : o_ang_ff[m2e_pkg::ANG_ROLL]);
   assign rsp_bus.degenerate  = sk_full_ff ? sk_degen_ff : o_degen_ff;

endmodule

### sv/m2e_checker.sv
`timescale 1ns / 1ps
`include "matrix_to_euler_angles_macros.svh"

module m2e_checker #(
   parameter int ANGLE_WIDTH = 32
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [ANGLE_WIDTH-2:0] yaw_angle,
   input logic signed [ANGLE_WIDTH-2:0] pitch_angle,
   input logic signed [ANGLE_WIDTH-2:0] roll_angle,
   input logic                          degenerate
);

   logic rsp_stall;
   assign rsp_stall = rsp_valid && !rsp_ready;

   // stalled result beat holds
   `M2E_ASSERT_CLK(a_rsp_hold, clock, reset, rsp_stall |=> rsp_valid && $stable(yaw_angle) && $stable(pitch_angle) && $stable(roll_angle) && $stable(degenerate), "stalled result beat changed")

   // degenerate matrix reports zero angles
   `M2E_ASSERT_CLK(a_degen_zero, clock, reset, rsp_valid && degenerate |-> yaw_angle == '0 && pitch_angle == '0 && roll_angle == '0, "degenerate beat with nonzero angle")

   // a stalled result fills the skid, so input must back off
   `M2E_ASSERT_CLK(a_stall_backpressure, clock, reset, rsp_stall |=> !req_ready, "input taken while skid full")

   // skid empty right after reset
   `M2E_ASSERT_ALWAYS(a_ready_after_reset, clock, $past(reset) && !reset |-> req_ready && !rsp_valid, "not ready after reset")

   // req_valid is only watched through the handshake; keep it referenced
   logic req_seen;
   assign req_seen = req_valid && req_ready;
   `M2E_ASSERT_CLK(a_no_out_from_reset, clock, reset, $past(reset) && !req_seen |-> !rsp_valid, "result right after reset")

endmodule

bind matrix_to_euler_angles m2e_checker #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_m2e_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_bus.valid),
   .req_ready   (req_bus.ready),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .yaw_angle   (rsp_bus.yaw_angle),
   .pitch_angle (rsp_bus.pitch_angle),
   .roll_angle  (rsp_bus.roll_angle),
   .degenerate  (rsp_bus.degenerate)
);
